@@ rtl/bb3_pkg.sv @@
package bb3_pkg;

  localparam int CH_W           = 8;
  localparam int PIX_W          = 3 * CH_W;
  localparam int IMG_W_W        = 11;
  localparam int IMG_H_W        = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_ADDR_W     = 1;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;

  // window sum: at most 9 x 255
  localparam int SUM_W       = 12;
  localparam int N_W         = 4;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam int OUT_FIFO_DEPTH = 16;
  // results that can be in flight behind an accepted item, plus the item itself
  localparam int OUT_SLACK      = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t bot;
    pix_t mid;
    pix_t top;
  } wcol_t;

  // one averaging job: column mask (bit k = window column k), row validity
  typedef struct packed {
    logic [2:0] cols;
    logic       top_ok;
    logic       bot_ok;
    logic       eof;
    logic       last;
  } op_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            last;
    logic            eof;
  } res_t;

  // zero acts as one, large values clip to the maximum
  function automatic int eff_dim(int v, int maxv);
    int r;
    r = v;
    if (r == 0) r = 1;
    if (r > maxv) r = maxv;
    return r;
  endfunction

  // ceil(2^16 / n); exact floor(m / n) for m < 4096
  function automatic logic [RECIP_W-1:0] recip(logic [N_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/bb3_if.sv @@
interface bb3_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [bb3_pkg::CH_W-1:0] in_blue;
  logic [bb3_pkg::CH_W-1:0] in_green;
  logic [bb3_pkg::CH_W-1:0] in_red;

  modport source (output valid, mode, in_blue, in_green, in_red, input ready);
  modport sink (input valid, mode, in_blue, in_green, in_red, output ready);
endinterface

interface bb3_out_if;
  logic                     valid;
  logic                     ready;
  logic [bb3_pkg::CH_W-1:0] out_blue;
  logic [bb3_pkg::CH_W-1:0] out_green;
  logic [bb3_pkg::CH_W-1:0] out_red;
  logic                     last_of_run;
  logic                     end_of_frame;

  modport source (output valid, out_blue, out_green, out_red, last_of_run, end_of_frame,
                  input ready);
  modport sink (input valid, out_blue, out_green, out_red, last_of_run, end_of_frame,
                output ready);
endinterface

@@ rtl/bb3_line_store.sv @@
module bb3_line_store #(
  parameter int DEPTH = bb3_pkg::DEF_MAX_WIDTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  bb3_pkg::pix_t       wr_above,
  input  bb3_pkg::pix_t       wr_mid,
  output bb3_pkg::pix_t       rd_above,
  output bb3_pkg::pix_t       rd_mid
);

  bb3_pkg::pix_t above_mem [DEPTH];
  bb3_pkg::pix_t mid_mem   [DEPTH];

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr] <= wr_above;
      mid_mem[wr_addr]   <= wr_mid;
    end
    if (rd_en) begin
      rd_above <= above_mem[rd_addr];
      rd_mid   <= mid_mem[rd_addr];
    end
  end

endmodule

@@ rtl/bb3_mean.sv @@
module bb3_mean (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  input  bb3_pkg::op_t         op,
  input  bb3_pkg::wcol_t [2:0] win,
  output logic                 res_valid,
  output bb3_pkg::res_t        res
);

  localparam int SW = bb3_pkg::SUM_W;
  localparam int CW = bb3_pkg::CH_W;
  localparam int PW = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

  logic [SW-1:0]                 sum_c [3];
  logic [SW-1:0]                 m_c   [3];
  logic [1:0]                    ncols;
  logic [1:0]                    nrows;
  logic [bb3_pkg::N_W-1:0]       n;

  logic                          m1_valid;
  logic [SW-1:0]                 m1_m [3];
  logic [bb3_pkg::RECIP_W-1:0]   m1_recip;
  logic                          m1_last;
  logic                          m1_eof;
  logic [PW-1:0]                 prod [3];

  // masked window sum per channel, rounding bias n/2 folded in
  always_comb begin
    ncols = 2'($countones(op.cols));
    nrows = 2'd1 + {1'b0, op.top_ok} + {1'b0, op.bot_ok};
    n     = bb3_pkg::N_W'({2'b00, ncols} * {2'b00, nrows});
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
      for (int k = 0; k < 3; k++) begin
        if (op.cols[k]) begin
          if (op.top_ok) sum_c[ch] = sum_c[ch] + SW'(win[k].top[ch*CW +: CW]);
          sum_c[ch] = sum_c[ch] + SW'(win[k].mid[ch*CW +: CW]);
          if (op.bot_ok) sum_c[ch] = sum_c[ch] + SW'(win[k].bot[ch*CW +: CW]);
        end
      end
      m_c[ch] = sum_c[ch] + SW'(n >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= op_valid;
    end
    m1_m     <= m_c;
    m1_recip <= bb3_pkg::recip(n);
    m1_last  <= op.last;
    m1_eof   <= op.eof;
  end

  // divide by n through the reciprocal
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PW'(m1_m[ch]) * PW'(m1_recip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= m1_valid;
    end
    res.blue  <= prod[0][bb3_pkg::RECIP_SHIFT +: CW];
    res.green <= prod[1][bb3_pkg::RECIP_SHIFT +: CW];
    res.red   <= prod[2][bb3_pkg::RECIP_SHIFT +: CW];
    res.last  <= m1_last;
    res.eof   <= m1_eof;
  end

endmodule

@@ rtl/bb3_out_fifo.sv @@
module bb3_out_fifo #(
  parameter int DEPTH = bb3_pkg::OUT_FIFO_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bb3_pkg::res_t     push_data,
  output logic [CNT_W-1:0]  count,
  bb3_out_if.source         pix_out
);

  bb3_pkg::res_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             pop;

  assign pop                  = pix_out.valid && pix_out.ready;
  assign pix_out.valid        = (count != '0);
  assign pix_out.out_blue     = mem[rd_ptr].blue;
  assign pix_out.out_green    = mem[rd_ptr].green;
  assign pix_out.out_red      = mem[rd_ptr].red;
  assign pix_out.last_of_run  = mem[rd_ptr].last;
  assign pix_out.end_of_frame = mem[rd_ptr].eof;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

@@ rtl/box_blur_3x3_rgb_top.sv @@
// 3x3 box blur over a raster stream of 24-bit BGR pixels. Each output channel is the
// mean of the in-frame pixels of the 3x3 window (clipped at the frame edges), rounded
// half up. Output lags input by one row and one pixel; after the last row the host
// sends image_width flush items (mode = 1) to drain the final row, and end_of_frame
// marks the bottom-right result. last_of_run marks the last result caused by one
// input transfer. Rate: one input transfer per clock while the output queue has room,
// except that an item in the last column of a row from the second row on, in frames
// at least two pixels wide, yields two results and holds off the next transfer; this
// is set by the single averaging unit, which produces one result per cycle. A result
// passes the stage-1 registers, the window and job registers and the two averaging
// registers into the output queue; a second row-end result first waits as a pending
// job. The two previous rows live in two synchronous line-store memories (one read
// and one write per cycle, forwarded when the same column is read and written back
// to back); they need no clearing pass, so the block takes input right after reset.
// Results wait in a 16-entry queue; input stalls while fewer than 8 entries are free.
// Write image_width / image_height only while the block is idle.
module box_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bb3_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
  bb3_in_if.sink                         pix_in,
  bb3_out_if.source                      pix_out
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W = $clog2(bb3_pkg::OUT_FIFO_DEPTH + 1);

  localparam logic [COL_W-1:0] WIDTH_M1_RST =
    COL_W'(bb3_pkg::eff_dim(bb3_pkg::RESET_WIDTH, MAX_WIDTH) - 1);
  localparam logic [ROW_W-1:0] HEIGHT_RST =
    ROW_W'(bb3_pkg::eff_dim(bb3_pkg::RESET_HEIGHT, MAX_HEIGHT));
  localparam logic [CNT_W-1:0] CNT_LIMIT =
    CNT_W'(bb3_pkg::OUT_FIFO_DEPTH - bb3_pkg::OUT_SLACK);

  // configuration, held as effective values (width kept as width - 1)
  logic [COL_W-1:0] width_m1;
  logic [ROW_W-1:0] height;

  // position of the next input
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  // accept-side decode
  logic          accept;
  logic          endrow, c_ge1, c_ge2, r_ge1, top_ok, bot_ok, row_done;
  logic          a_valid, b_valid;
  bb3_pkg::op_t  op_a, op_b;
  bb3_pkg::pix_t in_pix;
  logic          fwd_hit;

  // stage 1: line-store data back, write-back, window shift
  logic          s1_valid;
  logic [COL_W-1:0] s1_col;
  bb3_pkg::pix_t s1_pix;
  logic          s1_a_valid, s1_b_valid;
  bb3_pkg::op_t  s1_op_a, s1_op_b;
  logic          s1_fwd;
  bb3_pkg::pix_t s1_fwd_above, s1_fwd_mid;
  logic          s1_double;

  bb3_pkg::pix_t mem_above, mem_mid;
  bb3_pkg::pix_t above_eff, mid_eff;

  bb3_pkg::wcol_t [2:0] win;

  // averaging jobs; second job of a row end waits in the pending register
  logic          op_valid;
  bb3_pkg::op_t  op;
  logic          pend_valid;
  bb3_pkg::op_t  pend_op;

  logic          res_valid;
  bb3_pkg::res_t res;
  logic [CNT_W-1:0] fifo_count;

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  assign s1_double    = s1_valid && s1_a_valid && s1_b_valid;
  assign pix_in.ready = !s1_double && (fifo_count <= CNT_LIMIT);
  assign accept       = pix_in.valid && pix_in.ready;
  assign in_pix       = {pix_in.in_red, pix_in.in_green, pix_in.in_blue};

  assign endrow   = (col >= width_m1);
  assign c_ge1    = (col != '0);
  assign c_ge2    = ({1'b0, col} >= (COL_W + 1)'(2));
  assign r_ge1    = (row != '0);
  assign top_ok   = ({1'b0, row} >= (ROW_W + 1)'(2));
  assign bot_ok   = !pix_in.mode && (row < height);
  assign row_done = (row >= height);

  // result for (row-1, col-1), and the row-end result for (row-1, W-1)
  assign a_valid = r_ge1 && c_ge1;
  assign b_valid = r_ge1 && endrow;

  always_comb begin
    op_a.cols   = {1'b1, 1'b1, c_ge2};
    op_a.top_ok = top_ok;
    op_a.bot_ok = bot_ok;
    op_a.eof    = 1'b0;
    op_a.last   = !b_valid;
    op_b.cols   = {1'b1, c_ge1, 1'b0};
    op_b.top_ok = top_ok;
    op_b.bot_ok = bot_ok;
    op_b.eof    = row_done;
    op_b.last   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1 <= WIDTH_M1_RST;
      height   <= HEIGHT_RST;
      col      <= '0;
      row      <= '0;
    end else begin
      if (cfg_we) begin
        case (bb3_pkg::cfg_reg_t'(cfg_addr))
          bb3_pkg::CFG_IMAGE_WIDTH: begin
            width_m1 <= COL_W'(bb3_pkg::eff_dim(int'(cfg_data[bb3_pkg::IMG_W_W-1:0]),
                                                MAX_WIDTH) - 1);
          end
          bb3_pkg::CFG_IMAGE_HEIGHT: begin
            height <= ROW_W'(bb3_pkg::eff_dim(int'(cfg_data[bb3_pkg::IMG_H_W-1:0]),
                                              MAX_HEIGHT));
          end
          default: ;
        endcase
      end
      if (accept) begin
        if (endrow) begin
          col <= '0;
          row <= row_done ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. The item in stage 1 writes its column in the same cycle the next
  // item reads; on a match (one-pixel-wide frame) the written data is forwarded.
  // ---------------------------------------------------------------------------
  assign fwd_hit   = s1_valid && (s1_col == col);
  assign above_eff = s1_fwd ? s1_fwd_above : mem_above;
  assign mid_eff   = s1_fwd ? s1_fwd_mid   : mem_mid;

  bb3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (col),
    .wr_en    (s1_valid),
    .wr_addr  (s1_col),
    .wr_above (mid_eff),
    .wr_mid   (s1_pix),
    .rd_above (mem_above),
    .rd_mid   (mem_mid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_col       <= col;
      s1_pix       <= in_pix;
      s1_a_valid   <= a_valid;
      s1_b_valid   <= b_valid;
      s1_op_a      <= op_a;
      s1_op_b      <= op_b;
      s1_fwd       <= fwd_hit;
      s1_fwd_above <= mid_eff;
      s1_fwd_mid   <= s1_pix;
    end
  end

  // window: column 0 oldest, column 2 newest
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win[0]     <= win[1];
      win[1]     <= win[2];
      win[2].top <= above_eff;
      win[2].mid <= mid_eff;
      win[2].bot <= s1_pix;
    end
  end

  // ---------------------------------------------------------------------------
  // Job issue. A row end with two results blocks the next transfer, so the second
  // job, issued from the pending register, sees the same window.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid) begin
      op_valid   <= 1'b1;
      pend_valid <= 1'b0;
    end else if (s1_valid && s1_a_valid) begin
      op_valid   <= 1'b1;
      pend_valid <= s1_b_valid;
    end else if (s1_valid && s1_b_valid) begin
      op_valid   <= 1'b1;
    end else begin
      op_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid) begin
      op <= pend_op;
    end else if (s1_a_valid) begin
      op <= s1_op_a;
    end else begin
      op <= s1_op_b;
    end
    pend_op <= s1_op_b;
  end

  // ---------------------------------------------------------------------------
  // Averaging and output queue
  // ---------------------------------------------------------------------------
  bb3_mean u_mean (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .win       (win),
    .res_valid (res_valid),
    .res       (res)
  );

  bb3_out_fifo #(
    .DEPTH (bb3_pkg::OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .count     (fifo_count),
    .pix_out   (pix_out)
  );

endmodule

@@ tb/bb3_blur_checker.sv @@
`timescale 1ns / 100ps

module bb3_blur_checker
  import bb3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bb3_in_if                     pix_in,
  bb3_out_if                    pix_out,
  output int                    errors,
  output int                    pending,
  output int                    checked
);

  localparam int LINE_DEPTH = DEF_MAX_WIDTH;
  localparam int MAX_REPORTS = 40;

  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  pix_t               line_above [LINE_DEPTH];
  pix_t               line_mid [LINE_DEPTH];
  // [column oldest..newest][top, middle, bottom]
  pix_t               win [3][3];
  logic [IMG_H_W-1:0] row_cnt;
  logic [9:0]         col_cnt;
  res_t               blurred_q[$];
  res_t               want;
  int                 err_cnt = 0;
  int                 seen_cnt = 0;

  function automatic res_t box_mean(input logic [2:0] cols, input logic top_ok,
                                    input logic bot_ok, input logic eof);
    int   sum [3];
    int   n;
    int   k;
    int   row;
    int   ch;
    res_t r;
    n = 0;
    sum = '{0, 0, 0};
    for (k = 0; k < 3; k++) begin
      if (cols[k]) begin
        for (row = 0; row < 3; row++) begin
          if ((row == 0 && top_ok) || row == 1 || (row == 2 && bot_ok)) begin
            n++;
            for (ch = 0; ch < 3; ch++) sum[ch] += int'(win[k][row][8*ch +: 8]);
          end
        end
      end
    end
    // round half up
    r.blue  = CH_W'((2 * sum[0] + n) / (2 * n));
    r.green = CH_W'((2 * sum[1] + n) / (2 * n));
    r.red   = CH_W'((2 * sum[2] + n) / (2 * n));
    r.last  = 1'b0;
    r.eof   = eof;
    return r;
  endfunction

  task automatic blur_accept(input logic flush, input pix_t px);
    int   w;
    int   h;
    int   c;
    int   r;
    logic endrow;
    logic top_ok;
    logic bot_ok;
    logic has_inner;
    res_t inner;
    res_t edge_px;
    w = (width_reg == 0) ? 1 : ((int'(width_reg) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH
                                                                   : int'(width_reg));
    h = (height_reg == 0) ? 1 : ((int'(height_reg) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT
                                                                      : int'(height_reg));
    c = int'(col_cnt);
    r = int'(row_cnt);
    endrow = (c >= w - 1);
    top_ok = (r >= 2);
    bot_ok = !flush && (r < h);
    has_inner = 1'b0;

    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = line_above[c];
    win[2][1] = line_mid[c];
    win[2][2] = px;
    line_above[c] = line_mid[c];
    line_mid[c] = px;

    if (r >= 1) begin
      if (c >= 1) begin
        inner = box_mean({1'b1, 1'b1, c >= 2}, top_ok, bot_ok, 1'b0);
        has_inner = 1'b1;
      end
      if (endrow) begin
        edge_px = box_mean({1'b1, c >= 1, 1'b0}, top_ok, bot_ok, r >= h);
        edge_px.last = 1'b1;
      end else if (has_inner) begin
        inner.last = 1'b1;
      end
      if (has_inner) blurred_q.push_back(inner);
      if (endrow) blurred_q.push_back(edge_px);
    end

    if (endrow) begin
      col_cnt = '0;
      row_cnt = (r >= h) ? '0 : IMG_H_W'(r + 1);
    end else begin
      col_cnt = 10'(c + 1);
    end
  endtask

  task automatic check_field(input string fname, input logic [CH_W-1:0] exp_v,
                             input logic [CH_W-1:0] got_v);
    if (got_v !== exp_v) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = IMG_W_W'(RESET_WIDTH);
      height_reg = IMG_H_W'(RESET_HEIGHT);
      win = '{default: '0};
      row_cnt = '0;
      col_cnt = '0;
      blurred_q.delete();
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        seen_cnt++;
        if (blurred_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result with none expected, expected none, got b %0d g %0d r %0d",
                     $time, pix_out.out_blue, pix_out.out_green, pix_out.out_red);
        end else begin
          want = blurred_q.pop_front();
          check_field("out_blue", want.blue, pix_out.out_blue);
          check_field("out_green", want.green, pix_out.out_green);
          check_field("out_red", want.red, pix_out.out_red);
          check_field("last_of_run", CH_W'(want.last), CH_W'(pix_out.last_of_run));
          check_field("end_of_frame", CH_W'(want.eof), CH_W'(pix_out.end_of_frame));
        end
      end
      if (pix_in.valid && pix_in.ready)
        blur_accept(pix_in.mode, {pix_in.in_red, pix_in.in_green, pix_in.in_blue});
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data[IMG_W_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[IMG_H_W-1:0];
          default: ;
        endcase
      end
    end
    errors <= err_cnt;
    pending <= blurred_q.size();
    checked <= seen_cnt;
  end

endmodule

@@ tb/tb_box_blur_3x3_rgb_top.sv @@
`timescale 1ns / 100ps

module tb_box_blur_3x3_rgb_top;
  import bb3_pkg::*;

  // random frames stop once this many pixel transfers went through them
  localparam int RAND_ITEMS = 1700;
  // odd frames: zero width, zero height, both zero, one-pixel-wide column
  localparam int N_EXT = 4;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  // percent of cycles the sender / receiver sit idle
  int tx_idle_pct = 36;
  int rx_idle_pct = 58;

  // from the checker
  int mismatches;
  int awaiting;
  int results_seen;

  int sent_items = 0;
  int rand_items = 0;
  int frames = 0;
  int cur_w = RESET_WIDTH;
  int cur_h = RESET_HEIGHT;

  bb3_in_if  pix_in_ch ();
  bb3_out_if pix_out_ch ();

  box_blur_3x3_rgb_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .pix_in   (pix_in_ch),
    .pix_out  (pix_out_ch)
  );

  bb3_blur_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .pix_in  (pix_in_ch),
    .pix_out (pix_out_ch),
    .errors  (mismatches),
    .pending (awaiting),
    .checked (results_seen)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop, far above the slowest legal run (~2k items)
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // output side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    pix_out_ch.ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  // each channel: 0 / 255 often, so saturated sums and rounding edges show up
  function automatic pix_t rand_pixel();
    pix_t p;
    int   ch;
    for (ch = 0; ch < 3; ch++) begin
      case ($urandom_range(5))
        0:       p[8*ch +: 8] = 8'h00;
        1:       p[8*ch +: 8] = 8'hFF;
        default: p[8*ch +: 8] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  // one pixel transfer; called and returns at a falling edge, valid left high
  task automatic send_pixel(input logic flush, input pix_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in_ch.valid    <= 1'b1;
    pix_in_ch.mode     <= flush;
    pix_in_ch.in_blue  <= px[7:0];
    pix_in_ch.in_green <= px[15:8];
    pix_in_ch.in_red   <= px[23:16];
    do @(posedge clk); while (!pix_in_ch.ready);
    @(negedge clk);
    sent_items++;
  endtask

  // stop sending until every predicted result has come out, then settle
  task automatic drain_results(input int settle);
    pix_in_ch.valid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // register writes only when idle; the settle wait lets the pipeline empty
  task automatic set_dims(input int w_reg, input int h_reg);
    drain_results(8);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_IMAGE_WIDTH;
    cfg_data <= CFG_DATA_W'(w_reg);
    @(negedge clk);
    cfg_addr <= CFG_IMAGE_HEIGHT;
    cfg_data <= CFG_DATA_W'(h_reg);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_w = w_reg;
    cur_h = h_reg;
  endtask

  // Full frame: H rows of pixels plus one flush row of W items. Noise inside:
  // a few flush items mid-frame, and some real pixels in the flush row.
  task automatic run_frame(input int w_reg, input int h_reg, input bit new_dims);
    int wd;
    int ht;
    int total;
    int pause_at;
    int k;
    wd = (w_reg == 0) ? 1 : ((w_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w_reg);
    ht = (h_reg == 0) ? 1 : ((h_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h_reg);
    total = wd * (ht + 1);
    // first random frame always holds off mid-frame, later ones now and then
    pause_at = ($urandom_range(3) == 0 || frames == 3) ? $urandom_range(total - 1) : -1;
    if (new_dims) set_dims(w_reg, h_reg);
    for (k = 0; k < total; k++) begin
      if (k == pause_at) drain_results(0);
      if (k < wd * ht) send_pixel($urandom_range(15) == 0, rand_pixel());
      else send_pixel($urandom_range(7) != 0, rand_pixel());
    end
    frames++;
  endtask

  initial begin
    // {flush, red, green, blue}
    logic [24:0] seed_items [20];
    int          ext_w [N_EXT];
    int          ext_h [N_EXT];
    int          ext_idx;
    int          i;
    int          before_cnt;
    int          w_reg;
    int          h_reg;

    // 3x3: corners (n=4), edges (n=6), center (n=9); flush item mid-frame;
    // a real pixel in the flush row
    seed_items = '{
      25'h0_000000, 25'h0_FFFFFF, 25'h0_000000,
      25'h0_FF00FF, 25'h1_123456, 25'h0_00FF00,
      25'h0_FFFFFF, 25'h0_000000, 25'h0_80FF01,
      25'h1_FFFFFF, 25'h0_FFFFFF, 25'h1_000000,
      // 1x1: lone pixel (n=1)
      25'h0_FFFFFF, 25'h1_000000,
      // 2x2: every output is a corner
      25'h0_010203, 25'h0_FEFDFC, 25'h0_7F807F, 25'h0_000001,
      25'h1_000000, 25'h1_000000
    };
    ext_w = '{0, 9, 0, 1};
    ext_h = '{5, 0, 0, 30};
    ext_idx = 0;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_addr           = CFG_IMAGE_WIDTH;
    cfg_data           = '0;
    pix_in_ch.valid    = 1'b0;
    pix_in_ch.mode     = 1'b0;
    pix_in_ch.in_blue  = '0;
    pix_in_ch.in_green = '0;
    pix_in_ch.in_red   = '0;
    pix_out_ch.ready   = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed frames
    for (i = 0; i < 20; i++) begin
      if (i == 0) set_dims(3, 3);
      else if (i == 12) set_dims(1, 1);
      else if (i == 14) set_dims(2, 2);
      send_pixel(seed_items[i][24], seed_items[i][23:0]);
    end
    frames = 3;

    // random frames; idle profile moves through three phases
    while (rand_items < RAND_ITEMS || ext_idx < N_EXT) begin
      if (rand_items < RAND_ITEMS / 3) begin
        tx_idle_pct = 36;
        rx_idle_pct = 58;
      end else if (rand_items < 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 58;
        rx_idle_pct = 36;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if (ext_idx < N_EXT && (frames % 12 == 5 || rand_items >= RAND_ITEMS)) begin
        run_frame(ext_w[ext_idx], ext_h[ext_idx], 1'b1);
        ext_idx++;
      end else begin
        before_cnt = sent_items;
        if ($urandom_range(2) == 0 && frames > 3) begin
          // same size again, back to back with no idle gap
          run_frame(cur_w, cur_h, 1'b0);
        end else begin
          w_reg = ($urandom_range(7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
          h_reg = $urandom_range(1, 6);
          if ($urandom_range(19) == 0) w_reg = 0;
          if ($urandom_range(19) == 0) h_reg = 0;
          run_frame(w_reg, h_reg, 1'b1);
        end
        rand_items += sent_items - before_cnt;
      end
    end

    // let the pipeline empty out before the verdict
    drain_results(20);
    $display("Run covered %0d pixel transfers in %0d frames of assorted sizes, stalls on both sides,",
             sent_items, frames);
    $display("and compared %0d blurred output pixels.", results_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ box_blur_3x3_rgb_top.f @@
rtl/bb3_pkg.sv
rtl/bb3_if.sv
rtl/bb3_line_store.sv
rtl/bb3_mean.sv
rtl/bb3_out_fifo.sv
rtl/box_blur_3x3_rgb_top.sv
tb/bb3_blur_checker.sv
tb/tb_box_blur_3x3_rgb_top.sv
